[design/cmx_pkg.sv]
// cmx_pkg: shared types, register addresses and helpers for the cartridge mapper block
// no dependencies; imported by cartridge_mapper_exram_irq

package cmx_pkg;

    // request kinds carried on s_tuser
    typedef enum logic [2:0] {
        REQ_CPU_RD   = 3'd0,
        REQ_CPU_WR   = 3'd1,
        REQ_PPU_TICK = 3'd2,
        REQ_NT_RD    = 3'd3,
        REQ_NT_WR    = 3'd4
    } t_req_kind;

    // where a nametable access goes
    typedef enum logic [1:0] {
        NT_SRC_BLOCK  = 2'd0,
        NT_SRC_PAGE_A = 2'd1,
        NT_SRC_PAGE_B = 2'd2,
        NT_SRC_NONE   = 2'd3
    } t_nt_src;

    // how the result stage builds read_data
    typedef enum logic [1:0] {
        SEL_DIRECT = 2'd0,
        SEL_RAM    = 2'd1,
        SEL_ATTR   = 2'd2
    } t_data_sel;

    // cpu register map
    localparam logic [15:0] ADDR_RAM_MODE   = 16'h5104;
    localparam logic [15:0] ADDR_QUAD_MAP   = 16'h5105;
    localparam logic [15:0] ADDR_FILL_TILE  = 16'h5106;
    localparam logic [15:0] ADDR_FILL_ATTR  = 16'h5107;
    localparam logic [15:0] ADDR_SPLIT_CTRL = 16'h5200;
    localparam logic [15:0] ADDR_SPLIT_Y    = 16'h5201;
    localparam logic [15:0] ADDR_IRQ_LINE   = 16'h5203;
    localparam logic [15:0] ADDR_IRQ_STATUS = 16'h5204;
    localparam logic [15:0] ADDR_MUL_A      = 16'h5205;
    localparam logic [15:0] ADDR_MUL_B      = 16'h5206;
    // 0x5c00-0x5fff: top six address bits
    localparam logic [5:0]  XRAM_CPU_PAGE   = 6'b010111;

    // ppu timing
    localparam logic [8:0] DOT_LINE_END = 9'd337;
    localparam logic [8:0] LINE_PRE     = 9'd261;
    localparam logic [8:0] LINE_VBLANK  = 9'd240;

    // ram modes
    localparam logic [1:0] MODE_EXATTR = 2'd1;
    localparam logic [1:0] MODE_CPU_RW = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  open_bus;
        logic [8:0]  line_number;
        logic [8:0]  dot_number;
        logic        render_on;
    } t_item;

    typedef struct packed {
        t_data_sel   sel;
        logic        latch_ld;
        logic [7:0]  data;
        logic [1:0]  nt_source;
        logic [9:0]  page_addr;
        logic        irq_line;
        logic        frame_active;
    } t_res;

    // replicate a 2-bit palette code over all four attribute slots
    function automatic logic [7:0] spread2(input logic [1:0] b);
        return {b, b, b, b};
    endfunction

endpackage

[design/cmx_xram.sv]
// cmx_xram: extra ram storage, one write port and two registered read ports
// no dependencies; instantiated by cartridge_mapper_exram_irq

module cmx_xram #(
    parameter int WORDS = 1024,
    parameter int AW    = $clog2(WORDS)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr0,
    input  logic [AW-1:0] i_raddr1,
    output logic [7:0]    o_rdata0,
    output logic [7:0]    o_rdata1
);

    logic [7:0] r_mem [WORDS];
    logic [7:0] r_rdata0;
    logic [7:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

[design/cartridge_mapper_exram_irq.sv]
// cartridge_mapper_exram_irq: register file, extra ram, multiplier, scanline irq, nt routing
// the input beat is registered in stage a, then in the result register (stage b); one beat
// per cycle while m_tready drains stage b; the extra ram read port is registered between them
// reset (i_rst_n low, synchronous) clears the valid flags, control and mapper state, then a
// clearing pass writes 0xff into every extra ram word, with s_tready held low
// depends on cmx_pkg and cmx_xram

module cartridge_mapper_exram_irq #(
    parameter int EXTRA_RAM_WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[15:0], write_data[23:16], open_bus[31:24], line_number[40:32],
    // dot_number[49:41], render_on[50], zero fill[55:51]
    input  logic [55:0] s_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_tuser,
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], nt_source[9:8], page_addr[19:10], irq_line[20],
    // frame_active[21], zero fill[23:22]
    output logic [23:0] m_tdata
);

    import cmx_pkg::*;

    localparam int AW = $clog2(EXTRA_RAM_WORDS);

    // split-screen geometry
    localparam logic [6:0] SPLIT_TILES     = 7'd40;
    localparam logic [6:0] SPLIT_ROWS      = 7'd30;
    localparam logic [6:0] SPLIT_ROWS_2X   = 7'd60;
    localparam logic [6:0] TILE_LEAD       = 7'd2;
    localparam logic [9:0] EA_ATTR_BASE    = 10'h3C0;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    // ------------------------------------------------------------------
    // control: clearing pass after reset
    // ------------------------------------------------------------------
    t_state        r_state;
    logic [AW-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == AW'(EXTRA_RAM_WORDS - 1)) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_state <= ST_RUN;
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline handshake: input register (stage a) -> result register (stage b)
    // ------------------------------------------------------------------
    logic   r_a_valid;
    t_item  r_a;
    logic   r_b_valid;
    t_res   r_b;
    logic   w_adv;

    // stage a moves when the result register is free or being drained
    assign w_adv    = r_a_valid && (!r_b_valid || m_tready);
    assign s_tready = (r_state == ST_RUN) && (!r_a_valid || w_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_a_valid <= 1'b1;
        end else if (w_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_a.kind        <= s_tuser;
            r_a.address     <= s_tdata[15:0];
            r_a.write_data  <= s_tdata[23:16];
            r_a.open_bus    <= s_tdata[31:24];
            r_a.line_number <= s_tdata[40:32];
            r_a.dot_number  <= s_tdata[49:41];
            r_a.render_on   <= s_tdata[50];
        end
    end

    // ------------------------------------------------------------------
    // mapper state
    // ------------------------------------------------------------------
    logic [1:0] r_ram_mode,   n_ram_mode;
    logic [7:0] r_quad_map,   n_quad_map;
    logic [7:0] r_tile_fill,  n_tile_fill;
    logic [7:0] r_fill_attr,  n_fill_attr;
    logic [7:0] r_mul_a,      n_mul_a;
    logic [7:0] r_mul_b,      n_mul_b;
    logic [7:0] r_irq_target, n_irq_target;
    logic [7:0] r_line_cnt,   n_line_cnt;
    logic       r_irq_pend,   n_irq_pend;
    logic       r_irq_en,     n_irq_en;
    logic       r_frame_flag, n_frame_flag;
    logic       r_split_on,   n_split_on;
    logic       r_split_right, n_split_right;
    logic [4:0] r_split_col,  n_split_col;
    logic [7:0] r_split_sy,   n_split_sy;
    logic [7:0] r_attr_latch;

    // ------------------------------------------------------------------
    // stage a helpers
    // ------------------------------------------------------------------
    logic [15:0] w_prod;
    logic        w_is_attr;
    logic [1:0]  w_quad;
    logic        w_xram_page;
    logic [6:0]  w_tile_sum;
    logic [5:0]  w_tile;
    logic        w_split_in;
    logic [4:0]  w_cs;
    logic [6:0]  w_cy_sum;
    logic [6:0]  w_cy_s1;
    logic [4:0]  w_cy;
    logic [9:0]  w_ea;

    assign w_prod      = {8'd0, r_mul_a} * {8'd0, r_mul_b};
    assign w_is_attr   = (r_a.address[9:6] == 4'hF);
    // quadrant picks a 2-bit field of the mapping byte
    assign w_quad      = r_quad_map[{r_a.address[11:10], 1'b0} +: 2];
    assign w_xram_page = (r_a.address[15:10] == XRAM_CPU_PAGE);

    // tile column being fetched, two tiles ahead of the dot, wraps at 40
    assign w_tile_sum  = {1'b0, r_a.dot_number[8:3]} + TILE_LEAD;
    assign w_tile      = (w_tile_sum >= SPLIT_TILES) ? 6'(w_tile_sum - SPLIT_TILES)
                                                     : w_tile_sum[5:0];
    assign w_split_in  = r_split_right ? (w_tile >= {1'b0, r_split_col})
                                       : (w_tile <  {1'b0, r_split_col});

    // split row: coarse scroll plus coarse line, wraps at 30 (or 32 past it)
    assign w_cs        = r_split_sy[7:3];
    assign w_cy_sum    = {1'b0, r_a.line_number[8:3]} + {2'b00, w_cs};
    assign w_cy_s1     = (w_cy_sum >= SPLIT_ROWS_2X) ? (w_cy_sum - SPLIT_ROWS_2X) : w_cy_sum;
    assign w_cy        = ({2'b00, w_cs} < SPLIT_ROWS)
                         ? ((w_cy_s1 >= SPLIT_ROWS) ? 5'(w_cy_s1 - SPLIT_ROWS) : w_cy_s1[4:0])
                         : w_cy_sum[4:0];

    // tile fetch on odd dot pairs, attribute fetch otherwise
    assign w_ea = r_a.dot_number[1]
                  ? ({w_cy, 5'd0} | {4'd0, w_tile})
                  : (EA_ATTR_BASE | {4'd0, w_cy[4:2], 3'd0} | {6'd0, w_tile[5:2]});

    // ------------------------------------------------------------------
    // stage a: state update and result build
    // ------------------------------------------------------------------
    t_res          w_res;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic [AW-1:0] w_raddr0;
    logic [AW-1:0] w_raddr1;

    always_comb begin
        n_ram_mode    = r_ram_mode;
        n_quad_map    = r_quad_map;
        n_tile_fill   = r_tile_fill;
        n_fill_attr   = r_fill_attr;
        n_mul_a       = r_mul_a;
        n_mul_b       = r_mul_b;
        n_irq_target  = r_irq_target;
        n_line_cnt    = r_line_cnt;
        n_irq_pend    = r_irq_pend;
        n_irq_en      = r_irq_en;
        n_frame_flag  = r_frame_flag;
        n_split_on    = r_split_on;
        n_split_right = r_split_right;
        n_split_col   = r_split_col;
        n_split_sy    = r_split_sy;

        w_res.sel       = SEL_DIRECT;
        w_res.latch_ld  = 1'b0;
        w_res.data      = 8'd0;
        w_res.nt_source = NT_SRC_NONE;
        w_res.page_addr = 10'd0;

        w_we     = 1'b0;
        w_waddr  = r_a.address[AW-1:0];
        w_wdata  = r_a.write_data;
        w_raddr0 = r_a.address[AW-1:0];
        w_raddr1 = r_a.address[AW-1:0];

        case (r_a.kind)
            REQ_CPU_RD: begin
                if (r_a.address == ADDR_IRQ_STATUS) begin
                    w_res.data = {r_irq_pend, r_frame_flag, r_a.open_bus[5:0]};
                    n_irq_pend = 1'b0;
                end else if (r_a.address == ADDR_MUL_A) begin
                    w_res.data = w_prod[7:0];
                end else if (r_a.address == ADDR_MUL_B) begin
                    w_res.data = w_prod[15:8];
                end else if (w_xram_page && r_ram_mode >= MODE_CPU_RW) begin
                    w_res.sel = SEL_RAM;
                end else begin
                    w_res.data = r_a.open_bus;
                end
            end
            REQ_CPU_WR: begin
                case (r_a.address)
                    ADDR_RAM_MODE:   n_ram_mode   = r_a.write_data[1:0];
                    ADDR_QUAD_MAP:   n_quad_map   = r_a.write_data;
                    ADDR_FILL_TILE:  n_tile_fill  = r_a.write_data;
                    ADDR_FILL_ATTR:  n_fill_attr  = spread2(r_a.write_data[1:0]);
                    ADDR_SPLIT_CTRL: begin
                        n_split_on    = r_a.write_data[7];
                        n_split_right = r_a.write_data[6];
                        n_split_col   = r_a.write_data[4:0];
                    end
                    ADDR_SPLIT_Y:    n_split_sy   = r_a.write_data;
                    ADDR_IRQ_LINE:   n_irq_target = r_a.write_data;
                    ADDR_IRQ_STATUS: n_irq_en     = r_a.write_data[7];
                    ADDR_MUL_A:      n_mul_a      = r_a.write_data;
                    ADDR_MUL_B:      n_mul_b      = r_a.write_data;
                    default: begin
                        if (w_xram_page) begin
                            if (r_ram_mode <= MODE_EXATTR) begin
                                // outside a frame the cpu can only write zeros
                                w_we    = 1'b1;
                                w_wdata = r_frame_flag ? r_a.write_data : 8'd0;
                            end else if (r_ram_mode == MODE_CPU_RW) begin
                                w_we = 1'b1;
                            end
                        end
                    end
                endcase
            end
            REQ_PPU_TICK: begin
                if (!r_a.render_on ||
                    (r_a.line_number >= LINE_VBLANK && r_a.line_number != LINE_PRE)) begin
                    n_frame_flag = 1'b0;
                end else if (r_a.dot_number == DOT_LINE_END) begin
                    if (!r_frame_flag) begin
                        n_frame_flag = 1'b1;
                        n_line_cnt   = 8'd0;
                        n_irq_pend   = 1'b0;
                    end else begin
                        n_line_cnt = r_line_cnt + 8'd1;
                        if (n_line_cnt == r_irq_target) begin
                            n_irq_pend = 1'b1;
                        end
                    end
                end
            end
            REQ_NT_RD: begin
                if (r_ram_mode == MODE_EXATTR && w_is_attr) begin
                    // attribute byte comes from the latched tile entry
                    w_res.sel       = SEL_ATTR;
                    w_res.nt_source = NT_SRC_BLOCK;
                end else begin
                    w_res.latch_ld = (r_ram_mode == MODE_EXATTR);
                    if (r_split_on && r_ram_mode <= MODE_EXATTR && w_split_in) begin
                        w_res.sel       = SEL_RAM;
                        w_res.nt_source = NT_SRC_BLOCK;
                        w_raddr0        = AW'(w_ea);
                    end else begin
                        case (w_quad)
                            2'd0: begin
                                w_res.nt_source = NT_SRC_PAGE_A;
                                w_res.page_addr = r_a.address[9:0];
                            end
                            2'd1: begin
                                w_res.nt_source = NT_SRC_PAGE_B;
                                w_res.page_addr = r_a.address[9:0];
                            end
                            2'd2: begin
                                w_res.nt_source = NT_SRC_BLOCK;
                                if (r_ram_mode <= MODE_EXATTR) begin
                                    w_res.sel = SEL_RAM;
                                end
                            end
                            default: begin
                                w_res.nt_source = NT_SRC_BLOCK;
                                w_res.data      = w_is_attr ? r_fill_attr : r_tile_fill;
                            end
                        endcase
                    end
                end
            end
            REQ_NT_WR: begin
                case (w_quad)
                    2'd0: begin
                        w_res.nt_source = NT_SRC_PAGE_A;
                        w_res.page_addr = r_a.address[9:0];
                    end
                    2'd1: begin
                        w_res.nt_source = NT_SRC_PAGE_B;
                        w_res.page_addr = r_a.address[9:0];
                    end
                    2'd2: begin
                        w_res.nt_source = NT_SRC_BLOCK;
                        w_we            = (r_ram_mode <= MODE_EXATTR);
                    end
                    default: begin
                        w_res.nt_source = NT_SRC_NONE;
                    end
                endcase
            end
            default: begin
                // unused kinds leave state alone
            end
        endcase

        w_res.irq_line     = n_irq_pend && n_irq_en;
        w_res.frame_active = n_frame_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_mode    <= 2'd0;
            r_quad_map    <= 8'hFF;
            r_tile_fill   <= 8'd0;
            r_fill_attr   <= 8'd0;
            r_mul_a       <= 8'd0;
            r_mul_b       <= 8'd0;
            r_irq_target  <= 8'd0;
            r_line_cnt    <= 8'd0;
            r_irq_pend    <= 1'b0;
            r_irq_en      <= 1'b0;
            r_frame_flag  <= 1'b0;
            r_split_on    <= 1'b0;
            r_split_right <= 1'b0;
            r_split_col   <= 5'd0;
            r_split_sy    <= 8'd0;
        end else if (w_adv) begin
            r_ram_mode    <= n_ram_mode;
            r_quad_map    <= n_quad_map;
            r_tile_fill   <= n_tile_fill;
            r_fill_attr   <= n_fill_attr;
            r_mul_a       <= n_mul_a;
            r_mul_b       <= n_mul_b;
            r_irq_target  <= n_irq_target;
            r_line_cnt    <= n_line_cnt;
            r_irq_pend    <= n_irq_pend;
            r_irq_en      <= n_irq_en;
            r_frame_flag  <= n_frame_flag;
            r_split_on    <= n_split_on;
            r_split_right <= n_split_right;
            r_split_col   <= n_split_col;
            r_split_sy    <= n_split_sy;
        end
    end

    // ------------------------------------------------------------------
    // extra ram: clearing pass owns the write port until it is done
    // ------------------------------------------------------------------
    logic          w_clearing;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [7:0]    w_ram_wdata;
    logic [7:0]    w_ram_q0;
    logic [7:0]    w_ram_q1;

    assign w_clearing  = (r_state == ST_CLEAR);
    assign w_ram_we    = w_clearing || (w_adv && w_we);
    assign w_ram_waddr = w_clearing ? r_clr_idx : w_waddr;
    assign w_ram_wdata = w_clearing ? 8'hFF : w_wdata;

    cmx_xram #(
        .WORDS (EXTRA_RAM_WORDS),
        .AW    (AW)
    ) u_xram (
        .i_clk    (i_clk),
        .i_we     (w_ram_we),
        .i_waddr  (w_ram_waddr),
        .i_wdata  (w_ram_wdata),
        .i_re     (w_adv),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_ram_q0),
        .o_rdata1 (w_ram_q1)
    );

    // ------------------------------------------------------------------
    // stage b: result register, ram data joins here
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= 1'b1;
        end else if (m_tready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b <= w_res;
        end
    end

    // attribute latch follows result order, so a tile fetch updates it
    // just as the next beat reaches this stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_latch <= 8'd0;
        end else if (r_b_valid && m_tready && r_b.latch_ld) begin
            r_attr_latch <= w_ram_q1;
        end
    end

    logic [7:0] w_read_data;

    always_comb begin
        case (r_b.sel)
            SEL_RAM:  w_read_data = w_ram_q0;
            SEL_ATTR: w_read_data = spread2(r_attr_latch[7:6]);
            default:  w_read_data = r_b.data;
        endcase
    end

    assign m_tvalid = r_b_valid;
    assign m_tdata  = {2'b00, r_b.frame_active, r_b.irq_line, r_b.page_addr,
                       r_b.nt_source, w_read_data};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_beat_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !s_tready)
        else $error("input beat offered ready during extra ram clear");

    a_beat_enters_stage_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> r_a_valid)
        else $error("accepted beat lost before stage a");

    a_irq_rises_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq_pend) |-> ($past(w_adv) && $past(r_a.kind) == REQ_PPU_TICK))
        else $error("irq pending set by something other than a ppu tick");

    a_frame_falls_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_frame_flag) |-> ($past(w_adv) && $past(r_a.kind) == REQ_PPU_TICK))
        else $error("frame flag cleared by something other than a ppu tick");

endmodule
